### sv/affine_texture_span_mapper_top_defines.svh
// Assertion macros for the affine texture span mapper.
`ifndef AFFINE_TEXTURE_SPAN_MAPPER_TOP_DEFINES_SVH
`define AFFINE_TEXTURE_SPAN_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATSM_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ATSM_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

### sv/atsm_pkg.sv
package atsm_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [2:0] {
    MODE_PIXEL        = 3'd0,
    MODE_TEXEL_LOAD   = 3'd1,
    MODE_PALETTE_LOAD = 3'd2,
    MODE_BLEND_LOAD   = 3'd3,
    MODE_BLEND_ENABLE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    SHADE_PLAIN   = 2'd0,
    SHADE_PALETTE = 2'd1,
    SHADE_BLEND   = 2'd2
  } shade_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHADE_MODE = 3'd0,
    CFG_U_STEP     = 3'd1,
    CFG_V_STEP     = 3'd2,
    CFG_ROW_STRIDE = 3'd3,
    CFG_TEX_HEIGHT = 3'd4
  } cfg_idx_e;

  localparam logic [16:0] StrideReset = 17'd256;
  localparam logic [16:0] HeightReset = 17'd256;
  localparam logic [33:0] LimitReset  = 34'd65536;

  typedef struct packed {
    logic [2:0]  mode;
    logic        first;
    logic [31:0] u_start;
    logic [31:0] v_start;
    logic [7:0]  background;
    logic [15:0] load_addr;
    logic [7:0]  load_data;
  } span_in_t;

  typedef struct packed {
    logic       write_pixel;
    logic [7:0] pixel;
  } span_out_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  background;
    logic [15:0] load_addr;
    logic [7:0]  load_data;
  } item_t;

endpackage

### sv/atsm_stream_if.sv
interface atsm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/affine_texture_span_mapper_top.sv
// Affine texture span mapper: takes one item per clock while the pipeline is not held and
// offers one pixel result per pixel item; items pass stages s1 to s4 and the result is
// registered in an output register before the output transfer. Texture, palette and
// translucency tables live in synchronous memories; each memory is read and written at
// one fixed pipeline stage, so loads and pixels keep their order without forwarding.
// The pipeline holds only while the output register is full, not taken, and the last
// stage carries a result. No clearing pass: the stores hold nothing defined until
// loaded, and the per-colour translucency enables clear at reset.
`include "affine_texture_span_mapper_top_defines.svh"

module affine_texture_span_mapper_top #(
  parameter int TEX_DEPTH = 65536,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [atsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [atsm_pkg::CfgDataW-1:0]  cfg_data_i,
  atsm_stream_if.sink                    in_i,
  atsm_stream_if.source                  out_o
);

  localparam int TexAw = $clog2(TEX_DEPTH);
  localparam int IntW  = 32 - FRAC_BITS;
  localparam int ProdW = IntW + 18;
  localparam int OffW  = (IntW + 19 > 35) ? IntW + 19 : 35;

  logic [1:0]  shade_mode_q;
  logic [31:0] u_step_q, v_step_q;
  logic [16:0] row_stride_q, tex_height_q;
  logic [33:0] limit_q;

  logic [31:0] u_acc_q, u_acc_d, v_acc_q, v_acc_d;
  logic [31:0] u_sel, v_sel;

  logic adv, in_xfer, in_pix;

  logic                    v1_q, v2_q, v3_q, v4_q;
  atsm_pkg::item_t         s1_q, s2_q, s3_q, s4_q;
  logic signed [IntW-1:0]  s1_uint_q, s1_vint_q, s2_uint_q;
  logic signed [ProdW-1:0] s2_prod_q, prod;
  logic signed [OffW-1:0]  off_s;
  logic [OffW-1:0]         off;
  logic                    off_ok;

  logic [TexAw-1:0] tex_raddr, tex_waddr;
  logic             tex_we, tex_re, tex_load_ok;
  logic [7:0]       texel3;

  logic [7:0]  pal_addr, pal_rd;
  logic        pal_we, pal_re;
  logic [15:0] blend_addr;
  logic [7:0]  blend_rd;
  logic        blend_we, blend_re;

  logic [255:0] blend_en_q;
  logic         s4_en_q;
  logic [7:0]   s4_texel_q;

  logic                s2_pix, s3_pix, s4_pix;
  atsm_pkg::span_out_t res, out_q;
  logic                out_valid_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shade_mode_q <= atsm_pkg::SHADE_PLAIN;
      u_step_q     <= '0;
      v_step_q     <= '0;
      row_stride_q <= atsm_pkg::StrideReset;
      tex_height_q <= atsm_pkg::HeightReset;
      limit_q      <= atsm_pkg::LimitReset;
    end else begin
      limit_q <= tex_height_q * row_stride_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          atsm_pkg::CFG_SHADE_MODE: shade_mode_q <= cfg_data_i[1:0];
          atsm_pkg::CFG_U_STEP:     u_step_q     <= cfg_data_i;
          atsm_pkg::CFG_V_STEP:     v_step_q     <= cfg_data_i;
          atsm_pkg::CFG_ROW_STRIDE: row_stride_q <= cfg_data_i[16:0];
          atsm_pkg::CFG_TEX_HEIGHT: tex_height_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

  // handshake and coordinate accumulators
  assign s4_pix      = v4_q && (s4_q.mode == atsm_pkg::MODE_PIXEL);
  assign adv         = !s4_pix || !out_valid_q || out_o.ready;
  assign in_i.ready  = adv;
  assign in_xfer     = in_i.valid && adv;
  assign in_pix      = in_xfer && (in_i.data.mode == atsm_pkg::MODE_PIXEL);

  assign u_sel   = in_i.data.first ? in_i.data.u_start : u_acc_q;
  assign v_sel   = in_i.data.first ? in_i.data.v_start : v_acc_q;
  assign u_acc_d = u_sel + u_step_q;
  assign v_acc_d = v_sel + v_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_acc_q <= '0;
      v_acc_q <= '0;
    end else if (in_pix) begin
      u_acc_q <= u_acc_d;
      v_acc_q <= v_acc_d;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign prod = s1_vint_q * $signed({1'b0, row_stride_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.mode       <= in_i.data.mode;
      s1_q.background <= in_i.data.background;
      s1_q.load_addr  <= in_i.data.load_addr;
      s1_q.load_data  <= in_i.data.load_data;
      s1_uint_q       <= $signed(u_sel[31:FRAC_BITS]);
      s1_vint_q       <= $signed(v_sel[31:FRAC_BITS]);
      s2_q            <= s1_q;
      s2_uint_q       <= s1_uint_q;
      s2_prod_q       <= prod;
      s3_q            <= s2_q;
      s4_q            <= s3_q;
      s4_texel_q      <= texel3;
      s4_en_q         <= blend_en_q[texel3];
    end
  end

  // texture stage
  assign off_s  = OffW'(s2_prod_q) + OffW'(s2_uint_q);
  assign off    = off_s;
  assign off_ok = !off[OffW-1] && (off < OffW'(limit_q)) && (off < OffW'(TEX_DEPTH));
  assign s2_pix = v2_q && (s2_q.mode == atsm_pkg::MODE_PIXEL);

  assign tex_raddr   = off_ok ? off[TexAw-1:0] : '0;
  assign tex_load_ok = 32'(s2_q.load_addr) < 32'(TEX_DEPTH);
  assign tex_waddr   = TexAw'(s2_q.load_addr);
  assign tex_we      = adv && v2_q && (s2_q.mode == atsm_pkg::MODE_TEXEL_LOAD) && tex_load_ok;
  assign tex_re      = adv && s2_pix;

  atsm_ram #(
    .WIDTH (8),
    .DEPTH (TEX_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (tex_waddr),
    .wdata_i (s2_q.load_data),
    .re_i    (tex_re),
    .raddr_i (tex_raddr),
    .rdata_o (texel3)
  );

  // palette and translucency stage
  assign s3_pix     = v3_q && (s3_q.mode == atsm_pkg::MODE_PIXEL);
  assign pal_addr   = s3_pix ? texel3 : s3_q.load_addr[7:0];
  assign pal_we     = adv && v3_q && (s3_q.mode == atsm_pkg::MODE_PALETTE_LOAD)
                      && (s3_q.load_addr[15:8] == 8'd0);
  assign pal_re     = adv && s3_pix;
  assign blend_addr = s3_pix ? {texel3, s3_q.background} : s3_q.load_addr;
  assign blend_we   = adv && v3_q && (s3_q.mode == atsm_pkg::MODE_BLEND_LOAD);
  assign blend_re   = adv && s3_pix;

  atsm_ram #(
    .WIDTH (8),
    .DEPTH (256)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_addr),
    .wdata_i (s3_q.load_data),
    .re_i    (pal_re),
    .raddr_i (pal_addr),
    .rdata_o (pal_rd)
  );

  atsm_ram #(
    .WIDTH (8),
    .DEPTH (65536)
  ) u_blend_ram (
    .clk_i   (clk_i),
    .we_i    (blend_we),
    .waddr_i (blend_addr),
    .wdata_i (s3_q.load_data),
    .re_i    (blend_re),
    .raddr_i (blend_addr),
    .rdata_o (blend_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_en_q <= '0;
    end else if (adv && v3_q && (s3_q.mode == atsm_pkg::MODE_BLEND_ENABLE)
                 && (s3_q.load_addr[15:8] == 8'd0)) begin
      blend_en_q[s3_q.load_addr[7:0]] <= s3_q.load_data[0];
    end
  end

  // shading
  always_comb begin
    res.write_pixel = 1'b0;
    res.pixel       = 8'd0;
    if (s4_texel_q != 8'd0) begin
      res.write_pixel = 1'b1;
      case (shade_mode_q)
        atsm_pkg::SHADE_PALETTE: res.pixel = pal_rd;
        atsm_pkg::SHADE_BLEND:   res.pixel = s4_en_q ? blend_rd : s4_texel_q;
        default:                 res.pixel = s4_texel_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_pix || (out_valid_q && !out_o.ready);
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_pix) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `ATSM_ASSERT_NXT(a_acc_step, in_pix && !in_i.data.first, u_acc_q == $past(u_acc_q) + $past(u_step_q) && v_acc_q == $past(v_acc_q) + $past(v_step_q), "accumulator did not advance by the step")
  `ATSM_ASSERT_IMP(a_tex_one_access, 1'b1, !(tex_we && tex_re), "texture read and write in one cycle")
  `ATSM_ASSERT_IMP(a_stall_no_read, !adv, !tex_re && !pal_re && !blend_re && !tex_we, "memory access while stalled")
  `ATSM_ASSERT_NXT(a_result_kept, s4_pix && out_valid_q && !out_o.ready, out_valid_q && $stable(out_q) && v4_q, "pending result lost during stall")

endmodule

### sv/atsm_ram.sv
module atsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
